// ===== rtl/hash_set_intersection_top_assert.svh =====
// Assertion macros for the hash set intersection checker.
// Depends on nothing; included by the checker file.
`ifndef HASH_SET_INTERSECTION_TOP_ASSERT_SVH
`define HASH_SET_INTERSECTION_TOP_ASSERT_SVH

// Condition that must hold on every clock outside reset
`define HSI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold on the clock after the trigger
`define HSI_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hsi_pkg.sv =====
// Package for the hash set intersection engine: field widths, defaults, codes.
// Used by the top, the remainder unit and the testbench; depends on nothing.
package hsi_pkg;

  localparam int HSI_TABLE_BUCKETS = 8192;
  localparam int HSI_BUCKET_WAYS   = 8;
  localparam int HSI_MAX_ITEMS     = 4096;
  localparam int HSI_MAX_COMMON    = 4096;

  localparam int KEY_W = 31;
  localparam int POS_W = 12;
  localparam int CNT_W = 16;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_PROBE  = 2'd2,
    MODE_DRAIN  = 2'd3
  } mode_t;

endpackage

// ===== rtl/hash_set_intersection_top.sv =====
// Hash set intersection engine. One transaction in gives one transaction out.
// Insert and probe first work out key mod TABLE_BUCKETS in a reciprocal-multiply
// remainder unit, then read the bucket fill count; an insert ends there, a probe
// reads and compares one slot at a time, up to BUCKET_WAYS slots. A drain tests
// one accessed flag at a time from the drain pointer until it finds a marked entry
// or reaches the insert count. A clear, and the pass after reset, sweeps the fill
// and flag memories over max(TABLE_BUCKETS, MAX_ITEMS) addresses (8192 by
// default); no input is taken meanwhile. The input is accepted whenever the
// sequencer is idle, even while the previous result waits on m_tready.
module hash_set_intersection_top
  import hsi_pkg::*;
#(
  parameter int TABLE_BUCKETS = HSI_TABLE_BUCKETS,
  parameter int BUCKET_WAYS   = HSI_BUCKET_WAYS,
  parameter int MAX_ITEMS     = HSI_MAX_ITEMS,
  parameter int MAX_COMMON    = HSI_MAX_COMMON
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[1:0], key[32:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // found[0], key_out[31:1], position[43:32],
                                 // common_count[59:44], done_res[60],
                                 // overflow[61], zero fill
);

  localparam int BKW   = $clog2(TABLE_BUCKETS);
  localparam int WW    = $clog2(BUCKET_WAYS + 1);
  localparam int SLOTS = TABLE_BUCKETS * BUCKET_WAYS;
  localparam int SAW   = $clog2(SLOTS);
  localparam int IW    = $clog2(MAX_ITEMS);
  localparam int ICW   = $clog2(MAX_ITEMS + 1);
  localparam int SW    = KEY_W + IW;
  localparam int MAXD  = (TABLE_BUCKETS > MAX_ITEMS) ? TABLE_BUCKETS : MAX_ITEMS;
  localparam int CW    = $clog2(MAXD + 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_CLEAR   = 10'b0000000010,
    S_REM     = 10'b0000000100,
    S_FILL_RD = 10'b0000001000,
    S_FILL    = 10'b0000010000,
    S_PRB_RD  = 10'b0000100000,
    S_PRB_CMP = 10'b0001000000,
    S_DRN_RD  = 10'b0010000000,
    S_DRN_CHK = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t state;

  mode_t            cur_mode;
  logic [KEY_W-1:0] cur_key;
  logic [WW-1:0]    fill;
  logic [WW-1:0]    way;
  logic [ICW-1:0]   ins_cnt;
  logic [CNT_W-1:0] match_cnt;
  logic [ICW-1:0]   drain_ptr;
  logic [CW-1:0]    clr_cnt;
  logic             clr_res;

  logic             res_found;
  logic [KEY_W-1:0] res_key;
  logic [POS_W-1:0] res_pos;
  logic             res_done;
  logic             res_ovf;

  logic             out_found;
  logic [KEY_W-1:0] out_key;
  logic [POS_W-1:0] out_pos;
  logic [CNT_W-1:0] out_count;
  logic             out_done;
  logic             out_ovf;

  logic             in_acc;
  mode_t            in_mode;
  logic [KEY_W-1:0] in_key;

  logic             rem_start;
  logic             rem_done;
  logic [BKW-1:0]   bucket;

  logic             fill_we;
  logic [BKW-1:0]   fill_waddr;
  logic [WW-1:0]    fill_wdata;
  logic [WW-1:0]    fill_rd;

  logic             slot_we;
  logic [SAW-1:0]   slot_base;
  logic [SAW-1:0]   slot_waddr;
  logic [SAW-1:0]   slot_raddr;
  logic [SW-1:0]    slot_rd;
  logic [KEY_W-1:0] slot_key;
  logic [IW-1:0]    slot_idx;

  logic             flag_we;
  logic [IW-1:0]    flag_waddr;
  logic             flag_wdata;
  logic             flag_rd;

  logic             seq_we;
  logic [KEY_W-1:0] seq_rd;

  logic             ins_ok;
  logic             key_hit;
  logic             mark_ok;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign in_mode  = mode_t'(s_tdata[1:0]);
  assign in_key   = s_tdata[KEY_W+1:2];

  assign m_tdata = {2'b00, out_ovf, out_done, out_count, out_pos, out_key, out_found};

  assign rem_start = in_acc && (in_mode == MODE_INSERT || in_mode == MODE_PROBE);

  // Shared remainder unit
  hsi_remu #(
    .TABLE_BUCKETS(TABLE_BUCKETS)
  ) u_remu (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(in_key),
    .done    (rem_done),
    .rem     (bucket)
  );

  // Insert and probe decisions
  assign ins_ok   = (fill_rd < WW'(BUCKET_WAYS)) && (ins_cnt < ICW'(MAX_ITEMS));
  assign slot_key = slot_rd[KEY_W-1:0];
  assign slot_idx = slot_rd[SW-1:KEY_W];
  assign key_hit  = (slot_key == cur_key);
  assign mark_ok  = ({1'b0, match_cnt} < (CNT_W+1)'(MAX_COMMON));

  // Memory port control
  always_comb begin
    slot_base  = SAW'(bucket * BUCKET_WAYS);
    slot_waddr = slot_base + SAW'(fill_rd);
    slot_raddr = slot_base + SAW'(way);
    slot_we    = (state == S_FILL) && (cur_mode == MODE_INSERT) && ins_ok;
    seq_we     = slot_we;

    fill_we    = 1'b0;
    fill_waddr = bucket;
    fill_wdata = fill_rd + 1'b1;
    flag_we    = 1'b0;
    flag_waddr = drain_ptr[IW-1:0];
    flag_wdata = 1'b0;

    case (state)
      S_CLEAR: begin
        fill_waddr = clr_cnt[BKW-1:0];
        fill_wdata = '0;
        fill_we    = (clr_cnt < CW'(TABLE_BUCKETS));
        flag_waddr = clr_cnt[IW-1:0];
        flag_we    = (clr_cnt < CW'(MAX_ITEMS));
      end
      S_FILL: begin
        fill_we = slot_we;
      end
      S_PRB_CMP: begin
        flag_waddr = slot_idx;
        flag_wdata = 1'b1;
        flag_we    = key_hit && mark_ok;
      end
      S_DRN_CHK: begin
        flag_we = flag_rd;
      end
      default: begin
      end
    endcase
  end

  hsi_ram #(.WIDTH(WW), .DEPTH(TABLE_BUCKETS)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(bucket), .rdata(fill_rd)
  );

  hsi_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata({ins_cnt[IW-1:0], cur_key}),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  hsi_ram #(.WIDTH(1), .DEPTH(MAX_ITEMS)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(drain_ptr[IW-1:0]), .rdata(flag_rd)
  );

  hsi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_seq_ram (
    .clk(clk), .we(seq_we), .waddr(ins_cnt[IW-1:0]), .wdata(cur_key),
    .raddr(drain_ptr[IW-1:0]), .rdata(seq_rd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_res   <= 1'b0;
      ins_cnt   <= '0;
      match_cnt <= '0;
      drain_ptr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            cur_mode  <= in_mode;
            cur_key   <= in_key;
            res_found <= 1'b0;
            res_key   <= '0;
            res_pos   <= '0;
            res_done  <= 1'b0;
            res_ovf   <= 1'b0;
            case (in_mode)
              MODE_CLEAR: begin
                clr_cnt   <= '0;
                clr_res   <= 1'b1;
                ins_cnt   <= '0;
                match_cnt <= '0;
                drain_ptr <= '0;
                state     <= S_CLEAR;
              end
              MODE_DRAIN: state <= S_DRN_RD;
              default:    state <= S_REM;
            endcase
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(MAXD - 1)) begin
            state <= clr_res ? S_OUT : S_IDLE;
          end
        end
        S_REM: begin
          if (rem_done) begin
            state <= S_FILL_RD;
          end
        end
        S_FILL_RD: state <= S_FILL;
        S_FILL: begin
          if (cur_mode == MODE_INSERT) begin
            if (ins_ok) begin
              res_pos <= POS_W'(ins_cnt);
              ins_cnt <= ins_cnt + 1'b1;
            end else begin
              res_ovf <= 1'b1;
            end
            state <= S_OUT;
          end else if (fill_rd == '0) begin
            state <= S_OUT;
          end else begin
            fill  <= fill_rd;
            way   <= '0;
            state <= S_PRB_RD;
          end
        end
        S_PRB_RD: state <= S_PRB_CMP;
        S_PRB_CMP: begin
          if (key_hit) begin
            res_found <= 1'b1;
            res_key   <= cur_key;
            res_pos   <= POS_W'(slot_idx);
            if (match_cnt != {CNT_W{1'b1}}) begin
              match_cnt <= match_cnt + 1'b1;
            end
            state <= S_OUT;
          end else if (way + 1'b1 == fill) begin
            state <= S_OUT;
          end else begin
            way   <= way + 1'b1;
            state <= S_PRB_RD;
          end
        end
        S_DRN_RD: begin
          if (drain_ptr >= ins_cnt) begin
            res_done  <= 1'b1;
            drain_ptr <= '0;
            state     <= S_OUT;
          end else begin
            state <= S_DRN_CHK;
          end
        end
        S_DRN_CHK: begin
          // seq_rd is registered and lands in the cycle after the pointer; reuse S_DRN_CHK via res regs
          if (flag_rd) begin
            res_found <= 1'b1;
            res_pos   <= POS_W'(drain_ptr);
            state     <= S_OUT;
            clr_res   <= 1'b0;
          end else begin
            drain_ptr <= drain_ptr + 1'b1;
            state     <= S_DRN_RD;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (cur_mode == MODE_DRAIN && res_found) begin
              drain_ptr <= drain_ptr + 1'b1;
            end
            clr_res <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid  <= 1'b1;
      out_found <= res_found;
      out_key   <= (cur_mode == MODE_DRAIN && res_found) ? seq_rd : res_key;
      out_pos   <= res_pos;
      out_count <= match_cnt;
      out_done  <= res_done;
      out_ovf   <= res_ovf;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/hsi_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hsi_remu.sv =====
// Remainder unit: key mod TABLE_BUCKETS by reciprocal multiplication in multiply, subtract and fix phases.
// Depends on hsi_pkg.
module hsi_remu
  import hsi_pkg::*;
#(
  parameter int TABLE_BUCKETS = HSI_TABLE_BUCKETS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [KEY_W-1:0]                 dividend,
  output logic                             done,
  output logic [$clog2(TABLE_BUCKETS)-1:0] rem
);

  localparam int BKW = $clog2(TABLE_BUCKETS);
  localparam int SHF = KEY_W + BKW;
  // Floor of 2^SHF / TABLE_BUCKETS; the estimated quotient is short by at most one
  localparam logic [63:0]      RCP     = (64'd1 << SHF) / 64'(TABLE_BUCKETS);
  localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_BUCKETS);

  typedef enum logic [2:0] {
    R_MUL = 3'b001,
    R_SUB = 3'b010,
    R_FIX = 3'b100
  } rphase_t;

  logic             busy;
  rphase_t          phase;
  logic [KEY_W-1:0] kreg;
  logic [KEY_W-1:0] quo;
  logic [KEY_W-1:0] part;
  logic [63:0]      prod;
  logic [63:0]      qprod;

  // Quotient estimate and its back-multiplication
  always_comb begin
    prod  = 64'(kreg) * RCP;
    qprod = 64'(quo) * 64'(TABLE_BUCKETS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= R_MUL;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      phase <= R_MUL;
      kreg  <= dividend;
    end else if (busy) begin
      case (phase)
        R_MUL: begin
          quo   <= KEY_W'(prod >> SHF);
          phase <= R_SUB;
        end
        R_SUB: begin
          part  <= kreg - KEY_W'(qprod);
          phase <= R_FIX;
        end
        R_FIX: begin
          // Partial remainder is below twice the divisor
          rem   <= (part >= DIVISOR) ? BKW'(part - DIVISOR) : BKW'(part);
          busy  <= 1'b0;
          done  <= 1'b1;
          phase <= R_MUL;
        end
        default: phase <= R_MUL;
      endcase
    end
  end

endmodule

// ===== rtl/hsi_checker.sv =====
// Port-level checker for the hash set intersection engine, bound to the top.
// Depends on hash_set_intersection_top_assert.svh.
`include "hash_set_intersection_top_assert.svh"

module hsi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic [2:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  `HSI_ASSERT_ALWAYS(a_no_spurious_out, !m_tvalid || pend != 3'd0, "result without input")
  `HSI_ASSERT_ALWAYS(a_pend_bound, pend <= 3'd2, "too many transactions in flight")
  `HSI_ASSERT_ALWAYS(a_found_excl, !m_tvalid || !(m_tdata[0] && (m_tdata[60] || m_tdata[61])), "found with done or overflow")
  `HSI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind hash_set_intersection_top hsi_checker u_hsi_checker (.*);

// ===== tb/hash_set_intersection_top_tb.sv =====
// Testbench for hash_set_intersection_top: directed and random traffic,
// checked against a behavioral model of the bucket table. Depends on hsi_pkg and hash_set_intersection_top.
`timescale 1ns / 1ps

module hash_set_intersection_top_tb;
  import hsi_pkg::*;

  localparam int BUCKETS   = HSI_TABLE_BUCKETS;
  localparam int WAYS      = HSI_BUCKET_WAYS;
  localparam int ITEMS     = HSI_MAX_ITEMS;
  localparam int COMMON    = HSI_MAX_COMMON;
  localparam int STALL_MAX = 60000;

  typedef struct packed {
    logic             overflow;
    logic             done_res;
    logic [CNT_W-1:0] common_count;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key_out;
    logic             found;
  } hsi_result_t;

  // Table model plus queue of expected results
  class intersect_scoreboard;
    int unsigned      fill[BUCKETS];
    logic [KEY_W-1:0] way_key[BUCKETS*WAYS];
    int unsigned      way_pos[BUCKETS*WAYS];
    logic [KEY_W-1:0] order_key[ITEMS];
    bit               marked[ITEMS];
    int unsigned      n_inserted, n_matched, drain_at;
    hsi_result_t      pending_q[$];
    int               errors;

    function void wipe();
      foreach (fill[i]) fill[i] = 0;
      foreach (marked[i]) marked[i] = 0;
      n_inserted = 0;
      n_matched  = 0;
      drain_at   = 0;
    endfunction

    // Work out the result of one accepted transaction
    function void note(mode_t md, logic [KEY_W-1:0] k);
      hsi_result_t r;
      int unsigned b, f, i;
      bit hit;
      r   = '0;
      b   = k % BUCKETS;
      f   = fill[b];
      hit = 0;
      case (md)
        MODE_CLEAR: wipe();
        MODE_INSERT: begin
          if (f >= WAYS || n_inserted >= ITEMS) begin
            r.overflow = 1;
          end else begin
            way_key[b*WAYS+f] = k;
            way_pos[b*WAYS+f] = n_inserted;
            fill[b] = f + 1;
            order_key[n_inserted] = k;
            r.position = POS_W'(n_inserted);
            n_inserted++;
          end
        end
        MODE_PROBE: begin
          for (i = 0; i < f && !hit; i++) begin
            if (way_key[b*WAYS+i] == k) begin
              hit = 1;
              r.found = 1;
              r.key_out = k;
              r.position = POS_W'(way_pos[b*WAYS+i]);
            end
          end
          if (hit) begin
            if (n_matched < COMMON) marked[r.position] = 1;
            if (n_matched < 65535) n_matched++;
          end
        end
        default: begin
          for (i = drain_at; i < n_inserted && !hit; i++) begin
            if (marked[i]) begin
              hit = 1;
              marked[i] = 0;
              drain_at = i + 1;
              r.found = 1;
              r.key_out = order_key[i];
              r.position = POS_W'(i);
            end
          end
          if (!hit) begin
            drain_at = 0;
            r.done_res = 1;
          end
        end
      endcase
      r.common_count = CNT_W'(n_matched);
      pending_q.push_back(r);
    endfunction

    function void cmp_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    function void check(hsi_result_t got);
      hsi_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        return;
      end
      e = pending_q.pop_front();
      cmp_field("found", e.found, got.found);
      cmp_field("key_out", e.key_out, got.key_out);
      cmp_field("position", e.position, got.position);
      cmp_field("common_count", e.common_count, got.common_count);
      cmp_field("done_res", e.done_res, got.done_res);
      cmp_field("overflow", e.overflow, got.overflow);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // mode[1:0], key[32:2], zero fill
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;        // found, key_out, position, common_count, done_res, overflow

  intersect_scoreboard sb = new();
  bit          no_gaps = 0;
  int          stall_cycles = 0;
  logic [KEY_W-1:0] hi_pool[4];

  always #5 clk = ~clk;

  hash_set_intersection_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Monitor both sides and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note(mode_t'(s_tdata[1:0]), s_tdata[32:2]);
      if (m_tvalid && m_tready) sb.check(hsi_result_t'(m_tdata[61:0]));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 6);
  endfunction

  // Result side: random stall before each transaction
  initial begin
    int g;
    forever begin
      g = draw_gap();
      repeat (g) begin
        @(negedge clk);
        m_tready <= 0;
      end
      @(negedge clk);
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send(mode_t md, logic [KEY_W-1:0] k);
    int g;
    g = draw_gap();
    repeat (g) begin
      @(negedge clk);
      s_tvalid <= 0;
    end
    @(negedge clk);
    s_tvalid <= 1;
    s_tdata  <= {7'd0, k, md};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering input, then wait for every expected result
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 0;
    while (sb.pending_q.size() > 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pool_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom() & 32'h7FFF_FFFF);
    return KEY_W'(hi_pool[$urandom_range(0, 3)] * BUCKETS + $urandom_range(0, 15));
  endfunction

  initial begin
    int r, i;
    logic [KEY_W-1:0] k;
    sb.wipe();
    foreach (hi_pool[j]) hi_pool[j] = KEY_W'($urandom_range(0, 262143));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: empty table, extremes, full bucket, repeated key, drain passes
    send(MODE_DRAIN, 0);
    send(MODE_PROBE, 31'h7FFF_FFFF);
    send(MODE_INSERT, 0);
    send(MODE_INSERT, 31'h7FFF_FFFF);
    for (i = 0; i < WAYS + 1; i++) send(MODE_INSERT, KEY_W'(5 + BUCKETS * i));
    send(MODE_INSERT, 0);
    send(MODE_PROBE, 0);
    send(MODE_PROBE, 31'h7FFF_FFFF);
    send(MODE_PROBE, KEY_W'(5 + BUCKETS * (WAYS - 1)));
    send(MODE_PROBE, KEY_W'(5 + BUCKETS * WAYS));
    send(MODE_DRAIN, 31'h7FFF_FFFF);
    send(MODE_PROBE, 0);
    send(MODE_DRAIN, 0);
    send(MODE_DRAIN, 0);
    send(MODE_DRAIN, 0);
    send(MODE_DRAIN, 0);
    send(MODE_CLEAR, 31'h7FFF_FFFF);
    send(MODE_PROBE, 0);

    // Random traffic over a small key pool so buckets collide and fill
    for (i = 0; i < 620; i++) begin
      if (i % 100 == 50) no_gaps = ~no_gaps;
      if (i == 300) wait_drained();
      r = $urandom_range(0, 99);
      k = pool_key();
      if (r < 3) send(MODE_CLEAR, k);
      else if (r < 38) send(MODE_INSERT, k);
      else if (r < 75) send(MODE_PROBE, k);
      else send(MODE_DRAIN, k);
    end

    // Final drain passes, a clear and one more drain
    no_gaps = 0;
    for (i = 0; i < 4; i++) send(MODE_DRAIN, 0);
    send(MODE_CLEAR, 0);
    send(MODE_DRAIN, 0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
